### rtl/core/srt_pkg.sv
// Package for the sorted table: table depth, derived widths, status codes,
// sequencer states and the request/response structs between the modules.
// No dependencies.
package srt_pkg;

  // table capacity and derived widths
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;
  localparam int CNT_OUT_W = 7;

  // operation codes
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_LAST,
    S_REM_SCAN,
    S_FINISH
  } seq_state_t;

  // request into the sequencer
  typedef struct packed {
    op_t             op;
    logic [DW-1:0]   value;
  } srt_req_t;

  // response out of the sequencer
  typedef struct packed {
    status_t               status;
    logic [CNT_OUT_W-1:0]  count;
  } srt_rsp_t;

endpackage

### rtl/core/srt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module srt_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/srt_seq.sv
// Scan-and-shift sequencer for the sorted table: walks the entry RAM one
// entry per cycle, moving entries up (insert) or down (remove).
// Depends on srt_pkg and srt_ram.
module srt_seq
  import srt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  srt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output srt_rsp_t rsp
);

  seq_state_t      state, state_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [AW-1:0]   pa, pa_next;       // address whose read data arrives now
  logic            found, found_next;
  status_t         stat, stat_next;
  logic [DW-1:0]   val, val_next;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [DW-1:0]   wdata, rdata;
  logic [CW-1:0]   last_idx;
  logic            rd_less, rd_eq, rd_greater;

  srt_ram #(.DATA_W(DW), .ADDR_W(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // compare of the arriving entry against the operand
  assign rd_less    = $signed(rdata) < $signed(val);
  assign rd_eq      = rdata == val;
  assign rd_greater = !rd_less && !rd_eq;
  assign last_idx   = cnt - CW'(1);

  assign req_ready  = state == S_IDLE;
  assign rsp_valid  = state == S_FINISH;
  assign rsp.status = stat;
  assign rsp.count  = CNT_OUT_W'(cnt);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
    pa    <= pa_next;
    found <= found_next;
    stat  <= stat_next;
    val   <= val_next;
  end

  // next state, RAM control
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pa_next    = pa;
    found_next = found;
    stat_next  = stat;
    val_next   = val;
    we         = 1'b0;
    waddr      = pa + AW'(1);
    wdata      = rdata;
    raddr      = pa;
    case (state)
      S_IDLE: begin
        raddr = (req.op == OP_INSERT) ? AW'(last_idx) : '0;
        if (req_valid) begin
          val_next   = req.value;
          stat_next  = ST_DONE;
          found_next = 1'b0;
          if (req.op == OP_INSERT) begin
            pa_next = AW'(last_idx);
            if (cnt == CW'(DEPTH)) begin
              stat_next  = ST_FULL;
              state_next = S_FINISH;
            end else if (cnt == '0) begin
              // empty table: write straight to the bottom entry
              we         = 1'b1;
              waddr      = '0;
              wdata      = req.value;
              cnt_next   = CW'(1);
              state_next = S_FINISH;
            end else begin
              state_next = S_INS_SCAN;
            end
          end else begin
            pa_next = '0;
            if (cnt == '0) begin
              stat_next  = ST_NOT_FOUND;
              state_next = S_FINISH;
            end else begin
              state_next = S_REM_SCAN;
            end
          end
        end
      end
      // insert: walk down from the top, shifting entries up by one
      S_INS_SCAN: begin
        we    = 1'b1;
        waddr = pa + AW'(1);
        raddr = pa - AW'(1);
        if (rd_less) begin
          wdata      = val;
          cnt_next   = cnt + CW'(1);
          state_next = S_FINISH;
        end else begin
          wdata = rdata;
          if (pa == '0) begin
            state_next = S_INS_LAST;
          end else begin
            pa_next = pa - AW'(1);
          end
        end
      end
      // insert at the bottom entry
      S_INS_LAST: begin
        we         = 1'b1;
        waddr      = '0;
        wdata      = val;
        cnt_next   = cnt + CW'(1);
        state_next = S_FINISH;
      end
      // remove: walk up, find first match, then shift later entries down
      S_REM_SCAN: begin
        raddr = pa + AW'(1);
        waddr = pa - AW'(1);
        wdata = rdata;
        if (found) begin
          we = 1'b1;
        end else if (rd_eq) begin
          found_next = 1'b1;
        end
        if (!found && rd_greater) begin
          // passed the spot where the value would sit
          stat_next  = ST_NOT_FOUND;
          state_next = S_FINISH;
        end else if (CW'(pa) == last_idx) begin
          if (found || rd_eq) begin
            cnt_next = cnt - CW'(1);
          end else begin
            stat_next = ST_NOT_FOUND;
          end
          state_next = S_FINISH;
        end else begin
          pa_next = pa + AW'(1);
        end
      end
      S_FINISH: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/sorted_table_insert_remove_top.sv
// Sorted table of signed 32-bit values: insert in order / remove first match.
// Each request is handled alone. An insert scans down from the top entry,
// shifting every larger entry up by one; a remove scans up from the bottom,
// and once it finds its value every entry above the match is shifted down; a
// remove that misses stops at the first larger entry or at the top. An insert
// into a full table or a remove from an empty one goes straight to the result.
// The scan runs over the single entry RAM, one entry read and one entry moved
// per cycle. A new request is accepted once the previous result has moved into
// the output register, even while that result still waits to be taken.
// Depends on srt_pkg and srt_seq.
module sorted_table_insert_remove_top
  import srt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] count, [7] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  srt_req_t req;
  srt_rsp_t rsp, out_rsp;
  logic     rsp_valid, rsp_ready;

  assign req.op    = op_t'(s_tuser);
  assign req.value = s_tdata;

  srt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // output register
  assign rsp_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_tvalid <= rsp_valid;
    end
    if (rsp_ready && rsp_valid) begin
      out_rsp <= rsp;
    end
  end

  assign m_tdata = {1'b0, out_rsp.count};
  assign m_tuser = out_rsp.status;

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while sequencer busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[6:0] == CNT_OUT_W'(DEPTH))
    else $error("full status with count below capacity");

  a_rsp_hands_over: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready |=> m_tvalid && s_tready)
    else $error("response not moved to output register");

endmodule

### bench/tb_sorted_table_insert_remove_top.sv
// Testbench for sorted_table_insert_remove_top: directed table, then phased random
// insert/remove requests, each result checked against its typed-in expectation or
// an in-bench sorted list. Depends on srt_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_sorted_table_insert_remove_top;
  import srt_pkg::*;

  localparam int RANDOM_ITEMS = 730;
  localparam int QUIET_LIMIT  = 3000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES  = 400;   // long receiver stall for back pressure
  localparam int N_DIRECTED   = 22;

  typedef struct {
    status_t              status;
    logic [CNT_OUT_W-1:0] count;
  } result_t;

  typedef struct {
    op_t         op;
    logic [31:0] value;
    bit          fixed;   // expected result typed in below
    status_t     status;
    int          count;
  } step_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} mix_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;

  // sorted contents of the table as the bench believes them
  logic signed [31:0] sorted_vals[$];
  result_t            expected_results[$];

  // fields of the request currently offered, read back at acceptance
  bit      req_fixed;
  status_t req_status;
  int      req_count;

  bit sender_burst;
  bit receiver_burst;
  bit hold_pending;

  int errors;
  int n_results;
  int n_full;
  int n_absent;
  int quiet_cycles;

  // extremes, duplicates, absent values and the exact-match rule on remove
  step_t directed_steps [N_DIRECTED] = '{
    '{OP_REMOVE, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 0},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, ST_DONE,      1},
    '{OP_INSERT, 32'h8000_0000, 1'b1, ST_DONE,      2},
    '{OP_INSERT, 32'h0000_0000, 1'b1, ST_DONE,      3},
    '{OP_INSERT, 32'h0000_0000, 1'b1, ST_DONE,      4},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b1, ST_DONE,      5},
    '{OP_INSERT, 32'h0000_0001, 1'b0, ST_DONE,      0},
    '{OP_REMOVE, 32'h0000_0005, 1'b1, ST_NOT_FOUND, 6},
    '{OP_REMOVE, 32'hFFFF_FFFE, 1'b1, ST_NOT_FOUND, 6},
    '{OP_REMOVE, 32'h0000_0000, 1'b1, ST_DONE,      5},
    '{OP_REMOVE, 32'h0000_0000, 1'b1, ST_DONE,      4},
    '{OP_REMOVE, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 4},
    '{OP_REMOVE, 32'h8000_0000, 1'b1, ST_DONE,      3},
    '{OP_REMOVE, 32'h7FFF_FFFF, 1'b1, ST_DONE,      2},
    '{OP_INSERT, 32'h5555_5555, 1'b0, ST_DONE,      0},
    '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, ST_DONE,      0},
    '{OP_REMOVE, 32'h7FFF_FFFF, 1'b1, ST_NOT_FOUND, 4},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, ST_DONE,      0},
    '{OP_REMOVE, 32'h0000_0001, 1'b0, ST_DONE,      0},
    '{OP_REMOVE, 32'h5555_5555, 1'b0, ST_DONE,      0},
    '{OP_REMOVE, 32'hAAAA_AAAA, 1'b1, ST_DONE,      0},
    '{OP_REMOVE, 32'hAAAA_AAAA, 1'b1, ST_NOT_FOUND, 0}
  };

  sorted_table_insert_remove_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] value
    .s_tuser  (s_tuser),   // [0] opcode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [6:0] count, [7] zero
    .m_tuser  (m_tuser)    // [1:0] status
  );

  always #2 clk = ~clk;

  // apply one request to the sorted list and return its result
  function automatic result_t apply_request(op_t op, logic signed [31:0] v);
    result_t r;
    int      pos;
    pos = 0;
    while (pos < sorted_vals.size() && sorted_vals[pos] < v) pos++;
    r.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (sorted_vals.size() >= DEPTH) r.status = ST_FULL;
      else sorted_vals.insert(pos, v);
    end else begin
      if (pos < sorted_vals.size() && sorted_vals[pos] == v) sorted_vals.delete(pos);
      else r.status = ST_NOT_FOUND;
    end
    r.count = CNT_OUT_W'(sorted_vals.size());
    return r;
  endfunction

  function automatic int idle_cycles(bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // extremes, a narrow band for duplicates, stored values, or anything
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return 32'($urandom_range(0, 16)) - 32'd8;
      3: begin
        if (sorted_vals.size() > 0)
          return sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  // offer one request after a drawn gap and hold it until accepted
  task automatic send_request(op_t op, logic [31:0] v, bit fixed, status_t st, int cnt);
    int gap;
    gap = idle_cycles(sender_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_fixed  = fixed;
    req_status = st;
    req_count  = cnt;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // receiver: random gaps per result, one long stall on request
  initial begin : receiver
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = idle_cycles(receiver_burst);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // check results, predict accepted requests, watch for a hang
  always @(posedge clk) begin : monitor
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        n_results++;
        if (expected_results.size() == 0) begin
          errors++;
          $error("result with nothing expected: status %0d count %0d",
                 m_tuser, m_tdata[6:0]);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status) begin
            errors++;
            $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
          end
          if (m_tdata[6:0] !== want.count) begin
            errors++;
            $error("count mismatch: expected %0d, got %0d", want.count, m_tdata[6:0]);
          end
          if (m_tdata[7] !== 1'b0) begin
            errors++;
            $error("tdata pad mismatch: expected 0, got %b", m_tdata[7]);
          end
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_NOT_FOUND) n_absent++;
        end
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        want = apply_request(op_t'(s_tuser), s_tdata);
        if (req_fixed) begin
          want.status = req_status;
          want.count  = CNT_OUT_W'(req_count);
        end
        expected_results.push_back(want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // stimulus: directed rows, then fill / drain / mixed phases
  initial begin : stimulus
    int   sent;
    int   phase;
    int   len;
    mix_t mix;
    bit   is_remove;
    logic [31:0] v;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_steps[i])
      send_request(directed_steps[i].op, directed_steps[i].value, directed_steps[i].fixed,
                   directed_steps[i].status, directed_steps[i].count);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // first fill past capacity, then drain past empty, then random mixes
      if (phase == 0) mix = PH_FILL;
      else if (phase == 1) mix = PH_DRAIN;
      else mix = mix_t'($urandom_range(0, 2));
      len = (phase < 2) ? 90 : $urandom_range(30, 100);
      sender_burst   = ($urandom_range(0, 3) == 0);
      receiver_burst = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        sender_burst = 1'b1;
        hold_pending = 1'b1;
      end
      for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
        case (mix)
          PH_FILL:  is_remove = (phase == 0) ? 1'b0 : ($urandom_range(0, 4) == 0);
          PH_DRAIN: is_remove = (phase == 1) ? 1'b1 : ($urandom_range(0, 4) != 0);
          default:  is_remove = $urandom_range(0, 1);
        endcase
        if (is_remove && sorted_vals.size() > 0 && $urandom_range(0, 7) != 0)
          v = sorted_vals[$urandom_range(0, sorted_vals.size() - 1)];
        else
          v = pick_value();
        send_request(is_remove ? OP_REMOVE : OP_INSERT, v, 1'b0, ST_DONE, 0);
        sent++;
      end
      phase++;
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("Checked %0d results over %0d requests in %0d phases.",
             n_results, N_DIRECTED + sent, phase);
    $display("Table-full refusals: %0d, removes of absent values: %0d.", n_full, n_absent);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/srt_pkg.sv
rtl/core/srt_ram.sv
rtl/core/srt_seq.sv
rtl/core/sorted_table_insert_remove_top.sv
bench/tb_sorted_table_insert_remove_top.sv
